[sv/spq_pkg.sv]
package spq_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned HandleW = 16;
  localparam int unsigned KindW = 8;
  localparam int unsigned PrioW = 32;
  localparam int unsigned StatusW = 2;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  localparam logic [StatusW-1:0] StOk = 2'd0;
  localparam logic [StatusW-1:0] StBadHandle = 2'd1;
  localparam logic [StatusW-1:0] StFull = 2'd2;
  localparam logic [StatusW-1:0] StEmpty = 2'd3;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [KindW-1:0] kind;
    logic signed [PrioW-1:0] prio;
  } data_t;

  typedef struct packed {
    logic insert;
    logic remove;
    data_t data;
  } cmd_t;

endpackage

[sv/spq_cell.sv]
module spq_cell (
  input logic clk_i,
  input logic rst_ni,
  input spq_pkg::cmd_t cmd_i,
  input logic left_valid_i,
  input spq_pkg::data_t left_data_i,
  input logic left_le_i,
  input logic right_valid_i,
  input spq_pkg::data_t right_data_i,
  output logic valid_o,
  output spq_pkg::data_t data_o,
  output logic le_o,
  output logic match_o
);

  logic valid_q, valid_d;
  spq_pkg::data_t data_q, data_d;

  assign le_o = valid_q && (data_q.prio <= cmd_i.data.prio);
  assign match_o = valid_q && (data_q.handle == cmd_i.data.handle);

  always_comb begin
    valid_d = valid_q;
    data_d = data_q;
    if (cmd_i.remove) begin
      valid_d = right_valid_i;
      data_d = right_data_i;
    end else if (cmd_i.insert && !le_o) begin
      if (left_le_i) begin
        valid_d = 1'b1;
        data_d = cmd_i.data;
      end else begin
        valid_d = left_valid_i;
        data_d = left_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

[sv/stable_priority_queue.sv]
// An accepted item waits in the input register until the output register is free,
// then its result is registered. One item per cycle while out_ready_i is high;
// every successful insert or remove updates all cells of the shift-register chain
// at once, set by the per-cell compares and the OR of their handle matches.
// Reset clears the entry count, every cell's valid flag and both handshakes.
module stable_priority_queue (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  output logic in_ready_o,
  input logic opcode_i,
  input logic [15:0] item_handle_i,
  input logic [7:0] item_kind_i,
  input logic signed [31:0] item_priority_i,
  output logic out_valid_o,
  input logic out_ready_i,
  output logic [1:0] status_o,
  output logic [5:0] entry_count_o,
  output logic [15:0] out_handle_o,
  output logic [7:0] out_kind_o,
  output logic signed [31:0] out_priority_o
);

  localparam int unsigned N = spq_pkg::Capacity;

  logic busy_q, busy_d;
  logic op_q;
  spq_pkg::data_t in_q;
  logic [spq_pkg::CntW-1:0] count_q, count_d;
  logic out_valid_q, out_valid_d;
  logic [spq_pkg::StatusW-1:0] status_q, status_d;
  spq_pkg::data_t out_q, out_d;

  logic accept, exec, dup, full;
  spq_pkg::cmd_t cmd;

  logic [N-1:0] cell_valid, cell_le, cell_match;
  spq_pkg::data_t cell_data [N];

  assign exec = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || exec;
  assign accept = in_valid_i && in_ready_o;

  assign dup = |cell_match;
  assign full = (count_q == spq_pkg::CntW'(N));

  always_comb begin
    cmd.insert = 1'b0;
    cmd.remove = 1'b0;
    cmd.data = in_q;
    status_d = status_q;
    out_d = out_q;
    count_d = count_q;
    if (exec) begin
      out_d = '0;
      if (op_q == spq_pkg::OpInsert) begin
        if (in_q.handle == '0 || dup) begin
          status_d = spq_pkg::StBadHandle;
        end else if (full) begin
          status_d = spq_pkg::StFull;
        end else begin
          status_d = spq_pkg::StOk;
          cmd.insert = 1'b1;
          count_d = count_q + 1'b1;
        end
      end else begin
        if (count_q == '0) begin
          status_d = spq_pkg::StEmpty;
        end else begin
          status_d = spq_pkg::StOk;
          cmd.remove = 1'b1;
          out_d = cell_data[0];
          count_d = count_q - 1'b1;
        end
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (exec) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic left_valid, left_le, right_valid;
    spq_pkg::data_t left_data, right_data;

    if (i == 0) begin : g_head
      assign left_valid = 1'b0;
      assign left_data = '0;
      assign left_le = 1'b1;
    end else begin : g_mid
      assign left_valid = cell_valid[i-1];
      assign left_data = cell_data[i-1];
      assign left_le = cell_le[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_data = '0;
    end else begin : g_body
      assign right_valid = cell_valid[i+1];
      assign right_data = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk_i (clk_i),
      .rst_ni (rst_ni),
      .cmd_i (cmd),
      .left_valid_i (left_valid),
      .left_data_i (left_data),
      .left_le_i (left_le),
      .right_valid_i (right_valid),
      .right_data_i (right_data),
      .valid_o (cell_valid[i]),
      .data_o (cell_data[i]),
      .le_o (cell_le[i]),
      .match_o (cell_match[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      out_valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q <= busy_d;
      out_valid_q <= out_valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= opcode_i;
      in_q.handle <= item_handle_i;
      in_q.kind <= item_kind_i;
      in_q.prio <= item_priority_i;
    end
    status_q <= status_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign entry_count_o = 6'(count_q);
  assign out_handle_o = out_q.handle;
  assign out_kind_o = out_q.kind;
  assign out_priority_o = out_q.prio;

endmodule
